[hw/rtl/dda_line_rasterizer_defines.svh]
// Assertion macros used by the rasterizer datapath.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLR_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dlr_pkg.sv]
package dlr_pkg;

  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 32;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int SLOPE_BITS = FRAC_BITS + 2;
  localparam int LEFT_BITS  = COORD_BITS + 1;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int CNT_BITS   = (QUO_BITS > 1) ? $clog2(QUO_BITS) : 1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic signed [SLOPE_BITS-1:0] SLOPE_ONE =
    $signed(SLOPE_BITS'(1) << FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic start_load;
    logic div_step;
    logic start_emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic line_active;
    logic out_blocked;
  } status_t;

endpackage

[hw/rtl/dlr_ctrl.sv]
module dlr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             func,
  output logic             in_stall,
  input  dlr_pkg::status_t status,
  output dlr_pkg::cmd_t    cmd
);

  dlr_pkg::state_t state, state_next;
  logic [dlr_pkg::CNT_BITS-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      dlr_pkg::S_IDLE: begin
        in_stall = status.out_blocked;
        if (in_valid && !status.out_blocked) begin
          if (func == dlr_pkg::FUNC_START) begin
            cmd.start_load = 1'b1;
            cnt_next       = dlr_pkg::CNT_BITS'(dlr_pkg::QUO_BITS - 1);
            state_next     = dlr_pkg::S_DIV;
          end else if (status.line_active) begin
            cmd.advance = 1'b1;
          end
        end
      end
      dlr_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = dlr_pkg::S_EMIT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      dlr_pkg::S_EMIT: begin
        if (!status.out_blocked) begin
          cmd.start_emit = 1'b1;
          state_next     = dlr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dlr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlr_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[hw/rtl/dlr_datapath.sv]
`include "dda_line_rasterizer_defines.svh"

module dlr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  dlr_pkg::cmd_t                   cmd,
  output dlr_pkg::status_t                status,
  input  logic [dlr_pkg::COORD_BITS-1:0]  start_x,
  input  logic [dlr_pkg::COORD_BITS-1:0]  start_y,
  input  logic [dlr_pkg::COORD_BITS-1:0]  end_x,
  input  logic [dlr_pkg::COORD_BITS-1:0]  end_y,
  input  logic [dlr_pkg::COLOR_BITS-1:0]  line_color,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dlr_pkg::COORD_BITS-1:0]  pixel_x,
  output logic [dlr_pkg::COORD_BITS-1:0]  pixel_y,
  output logic [dlr_pkg::COLOR_BITS-1:0]  pixel_color,
  output logic                            last_pixel
);

  localparam int CB = dlr_pkg::COORD_BITS;
  localparam int FB = dlr_pkg::FRAC_BITS;
  localparam int AB = dlr_pkg::ACC_BITS;
  localparam int SB = dlr_pkg::SLOPE_BITS;
  localparam int LB = dlr_pkg::LEFT_BITS;
  localparam int QB = dlr_pkg::QUO_BITS;

  logic [CB-1:0]        major_pos;
  logic signed [AB-1:0] minor_acc;
  logic signed [SB-1:0] slope_step;
  logic [LB-1:0]        pixels_left;
  logic                 steep_line;
  logic [dlr_pkg::COLOR_BITS-1:0] held_color;
  logic                 line_active;

  logic [CB-1:0] divisor;
  logic          div_neg;
  logic [CB-1:0] rem;
  logic [QB-1:0] quo;

  logic [CB-1:0] adx, ady, ma0, ma1, mi0, mi1, sa0, sa1, si0, si1, span, mag;
  logic          steep, neg;

  always_comb begin
    adx   = (start_x > end_x) ? start_x - end_x : end_x - start_x;
    ady   = (start_y > end_y) ? start_y - end_y : end_y - start_y;
    steep = ady > adx;
    sa0   = steep ? start_y : start_x;
    sa1   = steep ? end_y   : end_x;
    si0   = steep ? start_x : start_y;
    si1   = steep ? end_x   : end_y;
    if (sa1 < sa0) begin
      ma0 = sa1;
      ma1 = sa0;
      mi0 = si1;
      mi1 = si0;
    end else begin
      ma0 = sa0;
      ma1 = sa1;
      mi0 = si0;
      mi1 = si1;
    end
    span = ma1 - ma0;
    neg  = mi1 < mi0;
    mag  = neg ? mi0 - mi1 : mi1 - mi0;
  end

  logic [CB:0]   trial, trial_diff;
  logic          trial_ok;
  logic [SB-1:0] quo_ext;
  logic signed [SB-1:0] slope_val;

  always_comb begin
    trial      = {rem, quo[QB-1]};
    trial_diff = trial - {1'b0, divisor};
    trial_ok   = trial >= {1'b0, divisor};
    quo_ext    = {1'b0, quo};
    if (divisor == '0) begin
      slope_val = '0;
    end else if (div_neg) begin
      slope_val = -$signed(quo_ext);
    end else begin
      slope_val = $signed(quo_ext);
    end
  end

  logic [CB-1:0]        major_adv;
  logic signed [AB-1:0] acc_adv;
  logic [LB-1:0]        left_adv;
  logic [CB-1:0]        em_major, em_minor;
  logic signed [AB-1:0] em_acc;
  logic [LB-1:0]        em_left;
  logic                 emit;

  always_comb begin
    major_adv = major_pos + 1'b1;
    acc_adv   = minor_acc + AB'(slope_step);
    left_adv  = pixels_left - 1'b1;
    em_major  = cmd.advance ? major_adv : major_pos;
    em_acc    = cmd.advance ? acc_adv : minor_acc;
    em_left   = cmd.advance ? left_adv : pixels_left;
    em_minor  = em_acc[AB-1] ? '0 : em_acc[FB+CB-1:FB];
    emit      = cmd.advance || cmd.start_emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      major_pos   <= ma0;
      minor_acc   <= $signed({1'b0, mi0, {FB{1'b0}}}) + $signed(AB'(1) << (FB - 1));
      pixels_left <= (span == '0) ? '0 : {1'b0, span} - 1'b1;
      steep_line  <= steep;
      held_color  <= line_color;
      divisor     <= span;
      div_neg     <= neg;
      rem         <= mag >> 1;
      quo         <= {mag[0], {FB{1'b0}}};
    end else if (cmd.div_step) begin
      rem <= trial_ok ? trial_diff[CB-1:0] : trial[CB-1:0];
      quo <= {quo[QB-2:0], trial_ok};
    end else if (cmd.advance) begin
      major_pos   <= major_adv;
      minor_acc   <= acc_adv;
      pixels_left <= left_adv;
    end
    if (cmd.start_emit) begin
      slope_step <= slope_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (emit) begin
      line_active <= em_left != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x     <= steep_line ? em_minor : em_major;
      pixel_y     <= steep_line ? em_major : em_minor;
      pixel_color <= held_color;
      last_pixel  <= em_left == '0;
    end
  end

  assign status.line_active = line_active;
  assign status.out_blocked = out_valid && out_stall;

  `DLR_CHECK_NOW(a_adv_needs_line, cmd.advance, line_active,
                 "Step issued with no active line.")
  `DLR_CHECK_NOW(a_emit_when_free, emit, !(out_valid && out_stall),
                 "Pixel overwrote a held beat.")
  `DLR_CHECK_NOW(a_slope_range, cmd.start_emit,
                 (slope_val <= dlr_pkg::SLOPE_ONE) && (slope_val >= -dlr_pkg::SLOPE_ONE),
                 "Slope magnitude exceeds one.")
  `DLR_CHECK_NEXT(a_emit_shows, emit, out_valid, "Emitted pixel not presented.")

endmodule

[hw/rtl/dda_line_rasterizer.sv]
// DDA line rasterizer.
// Input channel (in_valid / in_stall): a beat with func = 0 starts a new line from
// start_x/start_y to end_x/end_y in line_color; a beat with func = 1 advances one pixel.
// Output channel (out_valid / out_stall): one pixel beat per start beat, and one per
// step beat while a line is active; last_pixel marks the final pixel. The endpoint with
// the larger major-axis coordinate is not drawn; equal endpoints give one pixel.
// A step beat is accepted every cycle while no output beat is held stalled, and its pixel
// appears in the next cycle. A start beat holds in_stall high while a restoring divider
// forms the slope one quotient bit per cycle, and in S_EMIT until the output is free.
// A step beat while no line is active gives no pixel. A start beat abandons any line.
// The output beat sits in a register; while out_stall is high and a beat is held, the
// input side is stalled as well, so nothing is lost or repeated.
// Reset (rst, synchronous) empties the output register and leaves no line active.
module dda_line_rasterizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [dlr_pkg::COORD_BITS-1:0]  start_x,
  input  logic [dlr_pkg::COORD_BITS-1:0]  start_y,
  input  logic [dlr_pkg::COORD_BITS-1:0]  end_x,
  input  logic [dlr_pkg::COORD_BITS-1:0]  end_y,
  input  logic [dlr_pkg::COLOR_BITS-1:0]  line_color,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dlr_pkg::COORD_BITS-1:0]  pixel_x,
  output logic [dlr_pkg::COORD_BITS-1:0]  pixel_y,
  output logic [dlr_pkg::COLOR_BITS-1:0]  pixel_color,
  output logic                            last_pixel
);

  dlr_pkg::cmd_t    cmd;
  dlr_pkg::status_t status;

  dlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dlr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .line_color  (line_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule
